// ===== rtl/core/ist_pkg.sv =====
`default_nettype none

package ist_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int COORD_BITS = 32;
	localparam int ROT_BITS   = 16;
	localparam int N_CELLS    = 5;

	// Width of the translate-and-saturate sum: rounded magnitude (34 bits) plus sign,
	// or the coordinate width, with one bit of headroom.
	localparam int SUM_W = ((COORD_BITS > 35) ? COORD_BITS : 35) + 1;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [29:0] Q30_EIGHTH  = 30'h2000_0000;
	localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;

	typedef enum logic [1:0] {
		KIND_CROSS,
		KIND_BOX,
		KIND_ARROW,
		KIND_UNKNOWN
	} icon_kind_t;

	// Template coordinates in units of one half.
	typedef logic signed [2:0] tmpl_t;
	localparam tmpl_t ZERO   = 3'sd0;
	localparam tmpl_t P_HALF = 3'sd1;
	localparam tmpl_t N_HALF = -3'sd1;
	localparam tmpl_t N_ONE  = -3'sd2;

	// Indexed by kind, segment, then start x, start y, end x, end y.
	localparam tmpl_t TMPL [4][4][4] = '{
		'{'{N_HALF, ZERO, P_HALF, ZERO}, '{ZERO, N_HALF, ZERO, P_HALF},
		  '{ZERO, ZERO, ZERO, ZERO}, '{ZERO, ZERO, ZERO, ZERO}},
		'{'{N_HALF, N_HALF, P_HALF, N_HALF}, '{P_HALF, N_HALF, P_HALF, P_HALF},
		  '{P_HALF, P_HALF, N_HALF, P_HALF}, '{N_HALF, P_HALF, N_HALF, N_HALF}},
		'{'{N_ONE, P_HALF, ZERO, ZERO}, '{N_ONE, N_HALF, ZERO, ZERO},
		  '{ZERO, ZERO, ZERO, ZERO}, '{ZERO, ZERO, ZERO, ZERO}},
		'{'{ZERO, ZERO, ZERO, ZERO}, '{ZERO, ZERO, ZERO, ZERO},
		  '{ZERO, ZERO, ZERO, ZERO}, '{ZERO, ZERO, ZERO, ZERO}}
	};

	// Index of the final segment of each kind.
	localparam logic [1:0] SEG_LAST [4] = '{2'd1, 2'd3, 2'd1, 2'd0};

	// Horner divisors per cell. The sine series has one step fewer, so the
	// first cell passes the sine lane through.
	localparam logic       SIN_ON [N_CELLS] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
	localparam logic [6:0] K_SIN  [N_CELLS] = '{7'd72, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [6:0] K_COS  [N_CELLS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

	// Reciprocals floor(2^32 / k) for the divide-by-constant in each cell.
	localparam logic [31:0] M_SIN [N_CELLS] = '{
		32'(64'd4294967296 / 72), 32'(64'd4294967296 / 72), 32'(64'd4294967296 / 42),
		32'(64'd4294967296 / 20), 32'(64'd4294967296 / 6)
	};
	localparam logic [31:0] M_COS [N_CELLS] = '{
		32'(64'd4294967296 / 90), 32'(64'd4294967296 / 56), 32'(64'd4294967296 / 30),
		32'(64'd4294967296 / 12), 32'(64'd4294967296 / 2)
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [31:0]                  scale;
		icon_kind_t                   kind;
		logic [1:0]                   quad;
		logic                         folded;
		logic [29:0]                  x;
	} side_t;

	typedef struct packed {
		logic [29:0] x2;
		logic [30:0] ts;
		logic [30:0] tc;
		side_t       side;
	} horner_t;

endpackage

`default_nettype wire

// ===== rtl/core/ist_if.sv =====
`default_nettype none

interface ist_req_if import ist_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic [1:0]                   icon_kind;
	logic [ROT_BITS-1:0]          rotation;
	logic [31:0]                  size_factor;

	modport source (
		output valid, center_x, center_y, icon_kind, rotation, size_factor,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, icon_kind, rotation, size_factor,
		output ready
	);
endinterface

interface ist_seg_if import ist_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic                         last_segment;

	modport source (
		output valid, start_x, start_y, end_x, end_y, last_segment,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, end_x, end_y, last_segment,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/icon_segment_transform_top.sv =====
`default_nettype none

// Icon segment transform. Each request transaction on req names an icon kind, a
// center, a binary rotation angle and a Q16.16 scale; the block answers with the
// icon's line segments on seg, one transaction per segment, the final one
// flagged by last_segment. A box yields four segments and a cross or an arrow
// two; the result channel carries one segment per cycle while seg is ready.
// Requests of the unknown kind are taken and produce nothing. Sine and cosine
// come from a row of five Horner cells, three stages each. While seg is stalled
// the segment pipeline holds and the front end moves on only until it is full;
// req stays ready while the pipeline has room. There is no state between
// requests and nothing to clear after reset.
module icon_segment_transform_top import ist_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ist_req_if.sink   req,
	ist_seg_if.source seg
);

	logic fadv;
	logic adv;

	// Front end: angle preparation.
	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s3;
	logic                valid_s4;
	logic [ROT_BITS-1:0] rot_s1;
	side_t               side_s1;
	side_t               side_s2;
	horner_t             hin_s3;
	side_t               side_s4;
	logic [30:0]         s0_s4;
	logic [30:0]         c0_s4;

	logic [31:0] rot_ext;
	logic [31:0] a32;
	logic [29:0] rfrac;
	logic        folded;
	logic [29:0] fold;
	logic [59:0] xmul;
	logic [59:0] x2mul;
	logic [60:0] smul;

	logic    chain_v [N_CELLS+1];
	horner_t chain_h [N_CELLS+1];

	// Segment expander.
	logic                         exp_valid_q;
	logic [1:0]                   exp_idx_q;
	logic signed [31:0]           exp_sin_q;
	logic signed [31:0]           exp_cos_q;
	logic [31:0]                  exp_scale_q;
	logic signed [COORD_BITS-1:0] exp_cx_q;
	logic signed [COORD_BITS-1:0] exp_cy_q;
	icon_kind_t                   exp_kind_q;
	logic                         exp_last;
	logic                         exp_take;
	logic signed [31:0]           sr;
	logic signed [31:0]           cr;
	logic signed [31:0]           sin_m;
	logic signed [31:0]           cos_m;

	// Point pipeline and output register.
	logic pt_valid_s1;
	logic pt_valid_s2;
	logic pt_valid_s3;
	logic pt_last_s1;
	logic pt_last_s2;
	logic pt_last_s3;
	logic out_valid_q;
	logic out_last_q;

	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	assign adv      = !out_valid_q || seg.ready;
	assign exp_last = exp_idx_q == SEG_LAST[exp_kind_q];
	assign exp_take = !exp_valid_q || (exp_last && adv);
	assign fadv     = !valid_s4 || exp_take;
	assign req.ready = fadv;

	// Fold the angle into an eighth turn and convert it to radians in Q30.
	assign rot_ext = 32'(rot_s1);
	assign a32     = {rot_ext[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
	assign rfrac   = a32[29:0];
	assign folded  = rfrac > Q30_EIGHTH;
	assign fold    = folded ? 30'(Q30_ONE - 31'(rfrac)) : rfrac;
	assign xmul    = 60'(fold) * 60'(Q30_HALF_PI);
	assign x2mul   = 60'(side_s2.x) * 60'(side_s2.x);

	assign chain_v[0] = valid_s3;
	assign chain_h[0] = hin_s3;

	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		ist_horner_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (fadv),
			.din_valid  (chain_v[g]),
			.din        (chain_h[g]),
			.ks         (K_SIN[g]),
			.kc         (K_COS[g]),
			.ms         (M_SIN[g]),
			.mc         (M_COS[g]),
			.sin_on     (SIN_ON[g]),
			.dout_valid (chain_v[g+1]),
			.dout       (chain_h[g+1])
		);
	end

	assign smul = 61'(chain_h[N_CELLS].side.x) * 61'(chain_h[N_CELLS].ts);

	// Undo the fold and place sine and cosine in their quadrant.
	assign sr = $signed({1'b0, side_s4.folded ? c0_s4 : s0_s4});
	assign cr = $signed({1'b0, side_s4.folded ? s0_s4 : c0_s4});

	always_comb begin
		case (side_s4.quad)
			2'd0: begin
				sin_m = sr;
				cos_m = cr;
			end
			2'd1: begin
				sin_m = cr;
				cos_m = -sr;
			end
			2'd2: begin
				sin_m = -sr;
				cos_m = -cr;
			end
			default: begin
				sin_m = -cr;
				cos_m = sr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			exp_valid_q <= 1'b0;
			exp_idx_q   <= '0;
			pt_valid_s1 <= 1'b0;
			pt_valid_s2 <= 1'b0;
			pt_valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fadv) begin
				// An unknown kind is taken and dropped here.
				valid_s1 <= req.valid && (icon_kind_t'(req.icon_kind) != KIND_UNKNOWN);
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= chain_v[N_CELLS];
			end
			if (exp_take) begin
				exp_valid_q <= valid_s4;
				exp_idx_q   <= '0;
			end else if (adv) begin
				exp_idx_q <= exp_idx_q + 2'd1;
			end
			if (adv) begin
				pt_valid_s1 <= exp_valid_q;
				pt_valid_s2 <= pt_valid_s1;
				pt_valid_s3 <= pt_valid_s2;
				out_valid_q <= pt_valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fadv) begin
			rot_s1         <= req.rotation;
			side_s1.cx     <= req.center_x;
			side_s1.cy     <= req.center_y;
			side_s1.scale  <= req.size_factor;
			side_s1.kind   <= icon_kind_t'(req.icon_kind);
			side_s2.cx     <= side_s1.cx;
			side_s2.cy     <= side_s1.cy;
			side_s2.scale  <= side_s1.scale;
			side_s2.kind   <= side_s1.kind;
			side_s2.quad   <= a32[31:30];
			side_s2.folded <= folded;
			side_s2.x      <= xmul[59:30];
			hin_s3.x2      <= x2mul[59:30];
			hin_s3.ts      <= Q30_ONE;
			hin_s3.tc      <= Q30_ONE;
			hin_s3.side    <= side_s2;
			side_s4        <= chain_h[N_CELLS].side;
			s0_s4          <= smul[60:30];
			c0_s4          <= chain_h[N_CELLS].tc;
		end
		if (exp_take) begin
			exp_sin_q   <= sin_m;
			exp_cos_q   <= cos_m;
			exp_scale_q <= side_s4.scale;
			exp_cx_q    <= side_s4.cx;
			exp_cy_q    <= side_s4.cy;
			exp_kind_q  <= side_s4.kind;
		end
		if (adv) begin
			pt_last_s1 <= exp_last;
			pt_last_s2 <= pt_last_s1;
			pt_last_s3 <= pt_last_s2;
			out_last_q <= pt_last_s3;
		end
	end

	ist_point_unit u_start (
		.clk   (clk),
		.en    (adv),
		.sin_v (exp_sin_q),
		.cos_v (exp_cos_q),
		.a     (TMPL[exp_kind_q][exp_idx_q][0]),
		.b     (TMPL[exp_kind_q][exp_idx_q][1]),
		.cx    (exp_cx_q),
		.cy    (exp_cy_q),
		.scale (exp_scale_q),
		.ox    (start_x),
		.oy    (start_y)
	);

	ist_point_unit u_end (
		.clk   (clk),
		.en    (adv),
		.sin_v (exp_sin_q),
		.cos_v (exp_cos_q),
		.a     (TMPL[exp_kind_q][exp_idx_q][2]),
		.b     (TMPL[exp_kind_q][exp_idx_q][3]),
		.cx    (exp_cx_q),
		.cy    (exp_cy_q),
		.scale (exp_scale_q),
		.ox    (end_x),
		.oy    (end_y)
	);

	assign seg.valid        = out_valid_q;
	assign seg.start_x      = start_x;
	assign seg.start_y      = start_y;
	assign seg.end_x        = end_x;
	assign seg.end_y        = end_y;
	assign seg.last_segment = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/ist_horner_cell.sv =====
`default_nettype none

module ist_horner_cell import ist_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        din_valid,
	input  horner_t     din,
	input  logic [6:0]  ks,
	input  logic [6:0]  kc,
	input  logic [31:0] ms,
	input  logic [31:0] mc,
	input  logic        sin_on,
	output logic        dout_valid,
	output horner_t     dout
);

	typedef struct packed {
		horner_t     h;
		logic [30:0] ps;
		logic [30:0] pc;
	} prod_t;

	typedef struct packed {
		horner_t     h;
		logic [30:0] ps;
		logic [30:0] pc;
		logic [30:0] qs;
		logic [30:0] qc;
	} quot_t;

	logic        valid_s1;
	logic        valid_s2;
	prod_t       a_s1;
	quot_t       b_s2;
	logic [60:0] mul_s;
	logic [60:0] mul_c;
	logic [62:0] rcp_s;
	logic [62:0] rcp_c;
	logic [37:0] qk_s;
	logic [37:0] qk_c;
	logic [30:0] rem_s;
	logic [30:0] rem_c;
	logic [30:0] q_s;
	logic [30:0] q_c;
	horner_t     nxt;

	assign mul_s = 61'(din.x2) * 61'(din.ts);
	assign mul_c = 61'(din.x2) * 61'(din.tc);

	assign rcp_s = 63'(a_s1.ps) * 63'(ms);
	assign rcp_c = 63'(a_s1.pc) * 63'(mc);

	// The reciprocal estimate is exact or one short; one compare fixes it.
	assign qk_s  = 38'(b_s2.qs) * 38'(ks);
	assign qk_c  = 38'(b_s2.qc) * 38'(kc);
	assign rem_s = b_s2.ps - qk_s[30:0];
	assign rem_c = b_s2.pc - qk_c[30:0];
	assign q_s   = b_s2.qs + 31'(rem_s >= 31'(ks));
	assign q_c   = b_s2.qc + 31'(rem_c >= 31'(kc));

	always_comb begin
		nxt    = b_s2.h;
		nxt.ts = sin_on ? (Q30_ONE - q_s) : b_s2.h.ts;
		nxt.tc = Q30_ONE - q_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			dout_valid <= 1'b0;
		end else if (en) begin
			valid_s1   <= din_valid;
			valid_s2   <= valid_s1;
			dout_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1.h  <= din;
			a_s1.ps <= mul_s[60:30];
			a_s1.pc <= mul_c[60:30];
			b_s2.h  <= a_s1.h;
			b_s2.ps <= a_s1.ps;
			b_s2.pc <= a_s1.pc;
			b_s2.qs <= rcp_s[62:32];
			b_s2.qc <= rcp_c[62:32];
			dout    <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ist_point_unit.sv =====
`default_nettype none

module ist_point_unit import ist_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [31:0]           sin_v,
	input  logic signed [31:0]           cos_v,
	input  tmpl_t                        a,
	input  tmpl_t                        b,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic [31:0]                  scale,
	output logic signed [COORD_BITS-1:0] ox,
	output logic signed [COORD_BITS-1:0] oy
);

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	function automatic logic signed [33:0] term(input tmpl_t k, input logic signed [31:0] v);
		logic signed [33:0] e;
		e = 34'(v);
		case (k)
			P_HALF:  term = e;
			N_HALF:  term = -e;
			N_ONE:   term = -(e <<< 1);
			default: term = '0;
		endcase
	endfunction

	logic signed [33:0]           w     [2];
	logic [33:0]                  half  [2];
	logic signed [COORD_BITS-1:0] ctr   [2];
	logic signed [SUM_W-1:0]      sum   [2];
	logic signed [SUM_W-1:0]      rnd_e [2];

	logic [31:0]                  mag_s1 [2];
	logic                         neg_s1 [2];
	logic signed [COORD_BITS-1:0] ctr_s1 [2];
	logic [31:0]                  scale_s1;
	logic [63:0]                  prod_s2 [2];
	logic                         neg_s2 [2];
	logic signed [COORD_BITS-1:0] ctr_s2 [2];
	logic [33:0]                  rnd_s3 [2];
	logic                         neg_s3 [2];
	logic signed [COORD_BITS-1:0] ctr_s3 [2];
	logic signed [COORD_BITS-1:0] o_q    [2];

	assign w[0] = term(a, cos_v) - term(b, sin_v);
	assign w[1] = term(a, sin_v) + term(b, cos_v);
	assign ctr[0] = cx;
	assign ctr[1] = cy;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			// Halving with rounding away from zero: (|w| + 1) / 2.
			half[i]  = (w[i] < 0) ? 34'(~w[i] + 34'sd2) : 34'(w[i] + 34'sd1);
			rnd_e[i] = SUM_W'($signed({1'b0, rnd_s3[i]}));
			sum[i]   = neg_s3[i] ? (SUM_W'(ctr_s3[i]) - rnd_e[i])
			                     : (SUM_W'(ctr_s3[i]) + rnd_e[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s1 <= scale;
			for (int i = 0; i < 2; i++) begin
				mag_s1[i]  <= half[i][32:1];
				neg_s1[i]  <= w[i] < 0;
				ctr_s1[i]  <= ctr[i];
				prod_s2[i] <= 64'(mag_s1[i]) * 64'(scale_s1);
				neg_s2[i]  <= neg_s1[i];
				ctr_s2[i]  <= ctr_s1[i];
				rnd_s3[i]  <= prod_s2[i][63:30] + 34'(prod_s2[i][29]);
				neg_s3[i]  <= neg_s2[i];
				ctr_s3[i]  <= ctr_s2[i];
				if (sum[i] > SAT_HI) begin
					o_q[i] <= SAT_HI[COORD_BITS-1:0];
				end else if (sum[i] < SAT_LO) begin
					o_q[i] <= SAT_LO[COORD_BITS-1:0];
				end else begin
					o_q[i] <= sum[i][COORD_BITS-1:0];
				end
			end
		end
	end

	assign ox = o_q[0];
	assign oy = o_q[1];

endmodule

`default_nettype wire

// ===== test/icon_segment_transform_top_tb.sv =====
module icon_segment_transform_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ist_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_TAIL  = 40;
	localparam int PHASE_ITEMS = 82;

	localparam logic [63:0] Q30_UNIT    = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam longint      COORD_MAX   = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint      COORD_MIN   = -COORD_MAX - 1;

	localparam int H = 32768;
	localparam int F = 65536;

	// Template points in Q16.16: start x, start y, end x, end y per segment.
	localparam int SEG_TMPL [3][4][4] = '{
		'{'{-H, 0, H, 0}, '{0, -H, 0, H}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
		'{'{-H, -H, H, -H}, '{H, -H, H, H}, '{H, H, -H, H}, '{-H, H, -H, -H}},
		'{'{-F, H, 0, 0}, '{-F, -H, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}}
	};

	typedef struct {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		icon_kind_t                   kind;
		logic [ROT_BITS-1:0]          rot;
		logic [31:0]                  scale;
	} icon_req_t;

	typedef struct {
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
		logic                  last;
	} segment_t;

	logic clk;
	logic arst_n;

	ist_req_if req_ch ();
	ist_seg_if seg_ch ();

	icon_segment_transform_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.seg   (seg_ch)
	);

	segment_t pending_segments[$];
	int       mismatches      = 0;
	int       segments_seen   = 0;
	int       saturated_coords = 0;
	int       icons_by_kind[4] = '{0, 0, 0, 0};
	int       sender_idle_pct = 0;
	int       sink_stall_pct  = 0;
	int       hold_requests   = 0;
	int       hold_served     = 0;
	int       hold_left       = 0;
	int       quiet_cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint round_shift(longint v, int unsigned k);
		logic [63:0] m;
		m = (v < 0) ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (k - 1))) >> k;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
		if (v > COORD_MAX) begin
			saturated_coords++;
			return COORD_BITS'(COORD_MAX);
		end
		if (v < COORD_MIN) begin
			saturated_coords++;
			return COORD_BITS'(COORD_MIN);
		end
		return COORD_BITS'(v);
	endfunction

	// Sine and cosine in Q30 from a truncated Horner series on the folded octant.
	function automatic void unit_vector(input logic [15:0] ang, output longint s,
		output longint c);
		logic [31:0] a32;
		logic [63:0] r, f, x, x2, t, s0, c0;
		logic        folded;
		longint      sr, cr;
		int unsigned sin_div[4] = '{72, 42, 20, 6};
		int unsigned cos_div[5] = '{90, 56, 30, 12, 2};
		a32    = {ang, 16'h0000};
		r      = {34'd0, a32[29:0]};
		folded = r > (Q30_UNIT >> 1);
		f      = folded ? Q30_UNIT - r : r;
		x      = (f * HALF_PI_Q30) >> 30;
		x2     = (x * x) >> 30;
		t = Q30_UNIT;
		foreach (sin_div[i])
			t = Q30_UNIT - ((x2 * t) >> 30) / 64'(sin_div[i]);
		s0 = (x * t) >> 30;
		t = Q30_UNIT;
		foreach (cos_div[i])
			t = Q30_UNIT - ((x2 * t) >> 30) / 64'(cos_div[i]);
		c0 = t;
		sr = longint'(folded ? c0 : s0);
		cr = longint'(folded ? s0 : c0);
		case (a32[31:30])
			2'd0: begin
				s = sr;
				c = cr;
			end
			2'd1: begin
				s = cr;
				c = -sr;
			end
			2'd2: begin
				s = -sr;
				c = -cr;
			end
			default: begin
				s = -cr;
				c = sr;
			end
		endcase
	endfunction

	function automatic void place_point(input longint px, input longint py, input longint s,
		input longint c, input icon_req_t r, output logic [COORD_BITS-1:0] ox,
		output logic [COORD_BITS-1:0] oy);
		longint rx, ry, sx, sy;
		rx = round_shift(px * c - py * s, 16);
		ry = round_shift(px * s + py * c, 16);
		sx = round_shift(rx * longint'({32'd0, r.scale}), 30);
		sy = round_shift(ry * longint'({32'd0, r.scale}), 30);
		ox = clamp_coord(sx + longint'(r.cx));
		oy = clamp_coord(sy + longint'(r.cy));
	endfunction

	function automatic void predict_segments(icon_req_t r);
		longint   s, c;
		int       n;
		segment_t sg;
		icons_by_kind[r.kind]++;
		if (r.kind == KIND_UNKNOWN)
			return;
		unit_vector(r.rot, s, c);
		n = (r.kind == KIND_BOX) ? 4 : 2;
		for (int k = 0; k < n; k++) begin
			place_point(SEG_TMPL[r.kind][k][0], SEG_TMPL[r.kind][k][1], s, c, r, sg.sx, sg.sy);
			place_point(SEG_TMPL[r.kind][k][2], SEG_TMPL[r.kind][k][3], s, c, r, sg.ex, sg.ey);
			sg.last = (k == n - 1);
			pending_segments.push_back(sg);
		end
	endfunction

	function automatic icon_req_t make_icon(logic [31:0] cx, logic [31:0] cy, icon_kind_t kind,
		logic [15:0] rot, logic [31:0] scale);
		icon_req_t r;
		r.cx    = cx;
		r.cy    = cy;
		r.kind  = kind;
		r.rot   = rot;
		r.scale = scale;
		return r;
	endfunction

	function automatic logic [31:0] random_coord();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return $signed($urandom) >>> 6;
		endcase
	endfunction

	function automatic icon_req_t random_icon();
		icon_req_t r;
		r.cx   = random_coord();
		r.cy   = random_coord();
		r.kind = ($urandom_range(99) < 10) ? KIND_UNKNOWN : icon_kind_t'($urandom_range(2));
		case ($urandom_range(3))
			// Near a quadrant boundary, then near the octant fold.
			2: r.rot = 16'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
			3: r.rot = 16'(($urandom_range(3) << 14) + 32'h2000 + $urandom_range(2) - 1);
			default: r.rot = 16'($urandom_range(65535));
		endcase
		case ($urandom_range(19))
			0: r.scale = 32'd0;
			1: r.scale = 32'hFFFF_FFFF;
			2, 3, 4, 5, 6: r.scale = $urandom;
			7, 8, 9, 10: r.scale = 32'h0001_0000 + $urandom_range(255) - 128;
			default: r.scale = $urandom_range(32'h0004_0000);
		endcase
		return r;
	endfunction

	task automatic offer_icon(icon_req_t r);
		int gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.center_x    <= r.cx;
		req_ch.center_y    <= r.cy;
		req_ch.icon_kind   <= r.kind;
		req_ch.rotation    <= r.rot;
		req_ch.size_factor <= r.scale;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_segments(r);
	endtask

	// Must be called in a step where valid has not been assigned yet.
	task automatic wait_all_segments();
		req_ch.valid <= 1'b0;
		while (pending_segments.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random_icons(int count);
		repeat (count) offer_icon(random_icon());
		wait_all_segments();
	endtask

	task automatic test_directed();
		icon_req_t list[$];
		list.push_back(make_icon(0, 0, KIND_CROSS, 16'h0000, 32'h0001_0000));
		list.push_back(make_icon(32'h000A_0000, 32'hFFFD_0000, KIND_BOX, 16'h0000, 32'h0001_0000));
		list.push_back(make_icon(0, 0, KIND_ARROW, 16'h0000, 32'h0001_0000));
		list.push_back(make_icon(32'h0001_8000, 0, KIND_CROSS, 16'h4000, 32'h0002_0000));
		list.push_back(make_icon(0, 32'h0000_4000, KIND_BOX, 16'h8000, 32'h0001_0000));
		list.push_back(make_icon(0, 0, KIND_ARROW, 16'hC000, 32'h0000_8000));
		list.push_back(make_icon(0, 0, KIND_BOX, 16'h2000, 32'h0001_0000));
		list.push_back(make_icon(0, 0, KIND_ARROW, 16'h2001, 32'h0001_0000));
		list.push_back(make_icon(0, 0, KIND_CROSS, 16'hFFFF, 32'h0001_0000));
		list.push_back(make_icon(32'h0005_0000, 32'h0006_0000, KIND_UNKNOWN, 16'h1234,
			32'h0001_0000));
		// With zero scale every point collapses onto the center.
		list.push_back(make_icon(32'h1234_5678, 32'hEDCB_A988, KIND_BOX, 16'h1357, 32'd0));
		list.push_back(make_icon(32'h7FFF_FFFF, 32'h7FFF_FFFF, KIND_BOX, 16'h0000, 32'hFFFF_FFFF));
		list.push_back(make_icon(32'h8000_0000, 32'h8000_0000, KIND_BOX, 16'h0000, 32'hFFFF_FFFF));
		list.push_back(make_icon(0, 0, KIND_ARROW, 16'h6000, 32'hFFFF_FFFF));
		list.push_back(make_icon(32'h7FFF_FFFF, 32'h8000_0000, KIND_CROSS, 16'h0000,
			32'h0001_0000));
		list.push_back(make_icon(32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_UNKNOWN, 16'hFFFF,
			32'hFFFF_FFFF));
		list.push_back(make_icon(0, 0, KIND_BOX, 16'h0000, 32'd0));
		list.push_back(make_icon(32'h8000_0000, 32'h7FFF_FFFF, KIND_ARROW, 16'h8000,
			32'hFFFF_FFFF));
		list.push_back(make_icon(32'hFFF0_0000, 32'h0010_0000, KIND_CROSS, 16'hA000,
			32'h0003_4000));
		list.push_back(make_icon(0, 0, KIND_BOX, 16'h1FFF, 32'h0001_0000));
		list.push_back(make_icon(0, 0, KIND_UNKNOWN, 16'h0000, 32'd0));
		list.push_back(make_icon(32'h0000_0001, 32'hFFFF_FFFF, KIND_ARROW, 16'hE000,
			32'h0001_0000));
		foreach (list[i])
			offer_icon(list[i]);
		wait_all_segments();
	endtask

	// The output side holds off while requests keep coming, so the pipeline fills
	// and the input has to stall.
	task automatic test_backpressure();
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		hold_requests <= hold_requests + 1;
		repeat (30) offer_icon(random_icon());
		wait_all_segments();
	endtask

	task automatic test_free_flow();
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		run_random_icons(PHASE_ITEMS);
	endtask

	task automatic test_sender_gaps();
		sender_idle_pct = 47;
		sink_stall_pct  = 0;
		run_random_icons(PHASE_ITEMS);
	endtask

	task automatic test_sink_stalls();
		sender_idle_pct = 0;
		sink_stall_pct  = 47;
		run_random_icons(PHASE_ITEMS);
	endtask

	task automatic test_mixed_idle();
		sender_idle_pct = 27;
		sink_stall_pct  = 27;
		run_random_icons(PHASE_ITEMS);
	endtask

	task automatic compare_field(string name, logic [COORD_BITS-1:0] want,
		logic [COORD_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		seg_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				seg_ch.ready <= 1'b0;
			end else begin
				seg_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_segment
		segment_t want;
		if (arst_n && seg_ch.valid && seg_ch.ready) begin
			segments_seen++;
			if (pending_segments.size() == 0) begin
				$display("%0t ns: segment transaction with none expected: %h %h %h %h last %b",
					$time, seg_ch.start_x, seg_ch.start_y, seg_ch.end_x, seg_ch.end_y,
					seg_ch.last_segment);
				mismatches++;
			end else begin
				want = pending_segments.pop_front();
				compare_field("start_x", want.sx, seg_ch.start_x);
				compare_field("start_y", want.sy, seg_ch.start_y);
				compare_field("end_x", want.ex, seg_ch.end_x);
				compare_field("end_y", want.ey, seg_ch.end_y);
				compare_field("last_segment", COORD_BITS'(want.last),
					COORD_BITS'(seg_ch.last_segment));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (seg_ch.valid && seg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles, %0d segments outstanding",
					$time, quiet_cycles, pending_segments.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.center_x    <= '0;
		req_ch.center_y    <= '0;
		req_ch.icon_kind   <= '0;
		req_ch.rotation    <= '0;
		req_ch.size_factor <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_free_flow();
		test_sender_gaps();
		test_sink_stalls();
		test_mixed_idle();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (pending_segments.size() != 0) begin
			$display("%0t ns: %0d expected segments never arrived", $time,
				pending_segments.size());
			mismatches++;
		end
		$display("Covered %0d icons: %0d cross, %0d box, %0d arrow, %0d of unknown kind.",
			icons_by_kind[0] + icons_by_kind[1] + icons_by_kind[2] + icons_by_kind[3],
			icons_by_kind[0], icons_by_kind[1], icons_by_kind[2], icons_by_kind[3]);
		$display("%0d segments checked, %0d saturated coordinates, %0d mismatches.",
			segments_seen, saturated_coords, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ist_pkg.sv
rtl/core/ist_if.sv
rtl/core/ist_horner_cell.sv
rtl/core/ist_point_unit.sv
rtl/core/icon_segment_transform_top.sv
test/icon_segment_transform_top_tb.sv
